// ===== sv/skf_pkg.sv =====
// shared types, constants and cipher functions for the fixsliced skinny-128-384+ encryptor
// no dependencies
`timescale 1ns / 1ps

package skf_pkg;

	// request type codes
	localparam logic [1:0] REQ_TK1  = 2'd0;
	localparam logic [1:0] REQ_TK23 = 2'd1;
	localparam logic [1:0] REQ_ENC  = 2'd2;

	localparam int ROUNDS_DEF = 40;

	// round tweakey tables, split into four banks by word index bits [1:0]
	localparam int TK_BANKS   = 4;
	localparam int TK1_DEPTH  = 64;
	localparam int TK23_DEPTH = 160;
	localparam int TK1_ROWS   = TK1_DEPTH / TK_BANKS;
	localparam int TK23_ROWS  = TK23_DEPTH / TK_BANKS;
	localparam int TK1_ROW_W  = $clog2(TK1_ROWS);
	localparam int ROW_W      = $clog2(TK23_ROWS);

	localparam logic [31:0] HALF_MASK = 32'h5555_5555;
	localparam logic [31:0] M_0A      = 32'h0a0a_0a0a;
	localparam logic [31:0] M_30      = 32'h3030_3030;
	localparam logic [31:0] M_0C      = 32'h0c0c_0c0c;
	localparam logic [31:0] M_03      = 32'h0303_0303;
	localparam logic [31:0] M_C0      = 32'hc0c0_c0c0;

	typedef logic [3:0][31:0] slice_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic             wr_tk1;
		logic             wr_tk23;
		logic             pack_en;
		logic             round_en;
		logic [ROW_W-1:0] round;
		logic [ROW_W-1:0] rd_row;
		logic             out_load;
	} dp_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
		return (x >> r) | (x << (32 - r));
	endfunction

	// returns {a, b} after exchanging b & m with a & (m << n)
	function automatic logic [63:0] swp(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] m, input int unsigned n);
		logic [31:0] t;
		t = (b ^ (a >> n)) & m;
		return {a ^ (t << n), b ^ t};
	endfunction

	function automatic logic [31:0] swap_self(input logic [31:0] x, input logic [31:0] m,
			input int unsigned n);
		logic [31:0] t;
		t = (x ^ (x >> n)) & m;
		return x ^ t ^ (t << n);
	endfunction

	function automatic slice_t sbox_even(input slice_t s_in);
		slice_t s;
		s = s_in;
		s[3] = s[3] ^ ~(s[0] | s[1]);
		{s[2], s[1]} = swp(s[2], s[1], HALF_MASK, 1);
		{s[3], s[2]} = swp(s[3], s[2], HALF_MASK, 1);
		s[1] = s[1] ^ ~(s[2] | s[3]);
		{s[1], s[0]} = swp(s[1], s[0], HALF_MASK, 1);
		{s[0], s[3]} = swp(s[0], s[3], HALF_MASK, 1);
		s[3] = s[3] ^ ~(s[0] | s[1]);
		{s[2], s[1]} = swp(s[2], s[1], HALF_MASK, 1);
		{s[3], s[2]} = swp(s[3], s[2], HALF_MASK, 1);
		s[1] = s[1] ^ (s[2] | s[3]);
		{s[3], s[0]} = swp(s[3], s[0], HALF_MASK, 0);
		return s;
	endfunction

	function automatic slice_t sbox_odd(input slice_t s_in);
		slice_t s;
		s = s_in;
		s[1] = s[1] ^ ~(s[2] | s[3]);
		{s[0], s[3]} = swp(s[0], s[3], HALF_MASK, 1);
		{s[1], s[0]} = swp(s[1], s[0], HALF_MASK, 1);
		s[3] = s[3] ^ ~(s[0] | s[1]);
		{s[3], s[2]} = swp(s[3], s[2], HALF_MASK, 1);
		{s[2], s[1]} = swp(s[2], s[1], HALF_MASK, 1);
		s[1] = s[1] ^ ~(s[2] | s[3]);
		{s[0], s[3]} = swp(s[0], s[3], HALF_MASK, 1);
		{s[1], s[0]} = swp(s[1], s[0], HALF_MASK, 1);
		s[3] = s[3] ^ (s[0] | s[1]);
		{s[1], s[2]} = swp(s[1], s[2], HALF_MASK, 0);
		return s;
	endfunction

	function automatic logic [31:0] mix_word(input logic [31:0] x_in, input logic [1:0] v);
		logic [31:0] x;
		logic [31:0] t;
		x = x_in;
		unique case (v)
			2'd0: begin
				t = rotr(x, 24) & M_0C; x = x ^ rotr(t, 30);
				t = rotr(x, 16) & M_C0; x = x ^ rotr(t, 4);
				t = rotr(x, 8) & M_0C;  x = x ^ rotr(t, 2);
			end
			2'd1: begin
				t = rotr(x, 16) & M_30; x = x ^ rotr(t, 30);
				t = x & M_03;           x = x ^ rotr(t, 28);
				t = rotr(x, 16) & M_30; x = x ^ rotr(t, 2);
			end
			2'd2: begin
				t = rotr(x, 8) & M_C0;  x = x ^ rotr(t, 6);
				t = rotr(x, 16) & M_0C; x = x ^ rotr(t, 28);
				t = rotr(x, 24) & M_C0; x = x ^ rotr(t, 2);
			end
			default: begin
				t = x & M_03; x = x ^ rotr(t, 30);
				t = x & M_30; x = x ^ rotr(t, 4);
				t = x & M_03; x = x ^ rotr(t, 26);
			end
		endcase
		return x;
	endfunction

	function automatic slice_t pack_block(input logic [63:0] lo, input logic [63:0] hi);
		slice_t s;
		s[0] = lo[31:0];
		s[1] = hi[31:0];
		s[2] = lo[63:32];
		s[3] = hi[63:32];
		for (int q = 0; q < 4; q++) begin
			s[q] = swap_self(s[q], M_0A, 3);
		end
		{s[2], s[0]} = swp(s[2], s[0], M_30, 2);
		{s[1], s[0]} = swp(s[1], s[0], M_0C, 4);
		{s[3], s[0]} = swp(s[3], s[0], M_03, 6);
		{s[1], s[2]} = swp(s[1], s[2], M_0C, 2);
		{s[3], s[2]} = swp(s[3], s[2], M_03, 4);
		{s[3], s[1]} = swp(s[3], s[1], M_03, 2);
		return s;
	endfunction

	function automatic slice_t unpack_block(input slice_t s_in);
		slice_t s;
		s = s_in;
		{s[3], s[1]} = swp(s[3], s[1], M_03, 2);
		{s[3], s[2]} = swp(s[3], s[2], M_03, 4);
		{s[1], s[2]} = swp(s[1], s[2], M_0C, 2);
		{s[3], s[0]} = swp(s[3], s[0], M_03, 6);
		{s[1], s[0]} = swp(s[1], s[0], M_0C, 4);
		{s[2], s[0]} = swp(s[2], s[0], M_30, 2);
		for (int q = 0; q < 4; q++) begin
			s[q] = swap_self(s[q], M_0A, 3);
		end
		return s;
	endfunction

endpackage

// ===== sv/skf_req_if.sv =====
// request channel of the encryptor: key word loads and plaintext blocks
// no dependencies
`timescale 1ns / 1ps

interface skf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  word_index;
	logic [31:0] key_word;
	logic [63:0] block_low;
	logic [63:0] block_high;

	modport source (output valid, output req_type, output word_index, output key_word,
		output block_low, output block_high, input ready);
	modport sink (input valid, input req_type, input word_index, input key_word,
		input block_low, input block_high, output ready);
endinterface

// ===== sv/skf_res_if.sv =====
// result channel of the encryptor: ciphertext blocks
// no dependencies
`timescale 1ns / 1ps

interface skf_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_low;
	logic [63:0] cipher_high;

	modport source (output valid, output cipher_low, output cipher_high, input ready);
	modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

// ===== sv/skf_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module skf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/skf_ctrl.sv =====
// controller of the encryptor: request decode, round sequencing, result slot
// depends on skf_pkg
`timescale 1ns / 1ps

module skf_ctrl #(
	parameter int ROUNDS = skf_pkg::ROUNDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_type,
	input  logic [7:0]       word_index,
	output logic             req_ready,
	output logic             res_valid,
	input  logic             res_ready,
	output skf_pkg::dp_cmd_t cmd
);

	// whole quadruple rounds are run
	localparam int NR = 4 * ((ROUNDS + 3) / 4);

	skf_pkg::ctrl_state_t            state_q, state_d;
	logic [skf_pkg::ROW_W-1:0]       round_q, round_d;
	logic                            res_valid_q;
	logic                            last;

	assign last = round_q == skf_pkg::ROW_W'(NR - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skf_pkg::ST_IDLE;
			round_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.round = round_q;
		unique case (state_q)
			skf_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_type)
						skf_pkg::REQ_TK1: begin
							cmd.wr_tk1 = word_index < 8'(skf_pkg::TK1_DEPTH);
						end
						skf_pkg::REQ_TK23: begin
							cmd.wr_tk23 = word_index < 8'(skf_pkg::TK23_DEPTH);
						end
						skf_pkg::REQ_ENC: begin
							cmd.pack_en = 1'b1;
							round_d     = '0;
							state_d     = skf_pkg::ST_RUN;
						end
						default: ;
					endcase
				end
			end
			skf_pkg::ST_RUN: begin
				cmd.round_en = 1'b1;
				if (last) begin
					state_d = skf_pkg::ST_FIN;
				end else begin
					round_d    = round_q + 1'b1;
					cmd.rd_row = round_q + 1'b1;
				end
			end
			skf_pkg::ST_FIN: begin
				if (!res_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = skf_pkg::ST_IDLE;
				end
			end
			default: state_d = skf_pkg::ST_IDLE;
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// ===== sv/skf_datapath.sv =====
// datapath of the encryptor: tweakey banks, round unit, state and output registers
// depends on skf_pkg and skf_ram
`timescale 1ns / 1ps

module skf_datapath (
	input  logic             clk,
	input  skf_pkg::dp_cmd_t cmd,
	input  logic [7:0]       word_index,
	input  logic [31:0]      key_word,
	input  logic [63:0]      block_low,
	input  logic [63:0]      block_high,
	output logic [63:0]      cipher_low,
	output logic [63:0]      cipher_high
);

	logic [skf_pkg::TK_BANKS-1:0][31:0] tk1_rd, tk23_rd;
	skf_pkg::slice_t state_q, out_q;
	skf_pkg::slice_t sb, rk, mixed;

	for (genvar b = 0; b < skf_pkg::TK_BANKS; b++) begin : g_bank
		skf_ram #(
			.WIDTH (32),
			.DEPTH (skf_pkg::TK1_ROWS)
		) u_tk1 (
			.clk   (clk),
			.we    (cmd.wr_tk1 && word_index[1:0] == 2'(b)),
			.waddr (word_index[skf_pkg::TK1_ROW_W+1:2]),
			.wdata (key_word),
			.raddr (cmd.rd_row[skf_pkg::TK1_ROW_W-1:0]),
			.rdata (tk1_rd[b])
		);

		skf_ram #(
			.WIDTH (32),
			.DEPTH (skf_pkg::TK23_ROWS)
		) u_tk23 (
			.clk   (clk),
			.we    (cmd.wr_tk23 && word_index[1:0] == 2'(b)),
			.waddr (word_index[skf_pkg::ROW_W+1:2]),
			.wdata (key_word),
			.raddr (cmd.rd_row),
			.rdata (tk23_rd[b])
		);
	end

	// one round: s-box layer, tweakey addition, mixcolumns variant
	always_comb begin
		sb = cmd.round[0] ? skf_pkg::sbox_odd(state_q) : skf_pkg::sbox_even(state_q);
		for (int k = 0; k < 4; k++) begin
			rk[k]    = sb[k] ^ tk1_rd[k] ^ tk23_rd[k];
			mixed[k] = skf_pkg::mix_word(rk[k], cmd.round[1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack_en) begin
			state_q <= skf_pkg::pack_block(block_low, block_high);
		end else if (cmd.round_en) begin
			state_q <= mixed;
		end
		if (cmd.out_load) begin
			out_q <= skf_pkg::unpack_block(state_q);
		end
	end

	assign cipher_low  = {out_q[2], out_q[0]};
	assign cipher_high = {out_q[3], out_q[1]};

endmodule

// ===== sv/skinny_128_384_fixsliced_encrypt.sv =====
// skinny-128-384+ fixsliced encryptor, top level; depends on skf_pkg, skf_req_if, skf_res_if,
// skf_ctrl, skf_datapath. the ciphertext is registered in the output register once the
// NR = 4 * ceil(ROUNDS / 4) rounds have run; no new request is taken until then. the round unit
// does one round a cycle, fed by the banked tweakey tables; a ciphertext still waiting holds
// the next one in the finishing state. reset clears the controller and the result valid flag;
// tables are not reset
`timescale 1ns / 1ps

module skinny_128_384_fixsliced_encrypt #(
	parameter int ROUNDS = skf_pkg::ROUNDS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	skf_req_if.sink   req,
	skf_res_if.source res
);

	skf_pkg::dp_cmd_t cmd;

	// controller: accepts a request only when idle; a finished ciphertext waiting
	// in the output register does not hold off new requests, only the next handoff
	skf_ctrl #(
		.ROUNDS (ROUNDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_type   (req.req_type),
		.word_index (req.word_index),
		.req_ready  (req.ready),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.cmd        (cmd)
	);

	// datapath: tables are four banks each so a round reads its four words
	// at once; the read row is issued in the cycle before its round, as table reads are registered
	skf_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.word_index  (req.word_index),
		.key_word    (req.key_word),
		.block_low   (req.block_low),
		.block_high  (req.block_high),
		.cipher_low  (res.cipher_low),
		.cipher_high (res.cipher_high)
	);

	// rounds only run while no request is taken
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> !req.ready)
		else $error("request accepted while rounds are running");

	// an accepted encrypt request starts the rounds in the next cycle
	a_enc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == skf_pkg::REQ_ENC) |=> cmd.round_en)
		else $error("encrypt request did not start the rounds");

	// the output register is reloaded only once the previous ciphertext has left
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res.valid || res.ready))
		else $error("pending ciphertext overwritten");

	// table writes happen only for an accepted load request
	a_write_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_tk1 || cmd.wr_tk23) |-> (req.valid && req.ready))
		else $error("tweakey table written without a load request");

endmodule
